// ----- src/nbgr_pkg.sv -----
// Shared types and constants for the n-body gravity acceleration unit.
package nbgr_pkg;

    // One stored body, first field in the highest bits
    typedef struct packed {
        logic        [30:0] mass;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_x;
    } body_t;

    localparam int BODY_W = 159;

    // Configuration register indexes
    localparam logic [0:0] CFG_GR_COEF = 1'b0;
    localparam logic [0:0] CFG_THR     = 1'b1;

    localparam logic [47:0] GR_COEF_RESET = 48'd8346400;
    localparam logic [30:0] THR_RESET     = 31'd1049;

    // Arithmetic limits
    localparam int          ACC_W      = 48;
    localparam logic [31:0] F_CAP      = 32'hFFFF_FFFF;
    localparam logic [30:0] UNIT_CAP   = 31'h4000_0000;
    localparam logic [52:0] CORR_CAP   = 53'h10_0000_0000_0000;
    localparam logic [52:0] ONE_Q20    = 53'h10_0000;
    localparam logic [47:0] GR_SAT_LIM = 48'h10_0000_0000;
    localparam int          DIV_STEPS  = 32;
    localparam int          SQRT_STEPS = 32;

    // Divider request and response
    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic        ovf;
        logic [31:0] quo;
    } div_rsp_t;

    // Back end sequencer states
    typedef enum logic [5:0] {
        BK_IDLE, BK_KRD, BK_KLAT, BK_KM1, BK_KM2, BK_KM3, BK_KM4, BK_KM5, BK_KSET,
        BK_JRD, BK_JLAT, BK_JSQX, BK_JSQY, BK_JR2, BK_JSQRT,
        BK_JBASE, BK_JBASEW, BK_JQ, BK_JQW, BK_JQ2, BK_JC1, BK_JC2, BK_JCORR,
        BK_JFAC, BK_JF1, BK_JF2, BK_JF, BK_JUX, BK_JUXW, BK_JUY, BK_JUYW,
        BK_JTX, BK_JTY, BK_JACC, BK_KOUT, BK_DONE
    } bk_state_t;

endpackage

// ----- src/nbgr_div.sv -----
// Restoring divider, one quotient bit per cycle, 32-bit quotient with overflow flag.
module nbgr_div (
    input  logic               clk,
    input  logic               rst_n,
    input  nbgr_pkg::div_req_t req,
    output nbgr_pkg::div_rsp_t rsp
);
    import nbgr_pkg::*;

    logic        run_reg;
    logic        done_reg;
    logic        ovf_reg;
    logic [4:0]  cnt_reg;
    logic [63:0] rem_reg;
    logic [31:0] lo_reg;
    logic [31:0] quo_reg;
    logic [63:0] den_reg;
    logic [64:0] trial;
    logic        ge;

    // Shift in the next dividend bit and test against the divisor
    assign trial = {rem_reg, lo_reg[31]};
    assign ge    = trial >= {1'b0, den_reg};

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                cnt_reg <= '0;
                if (req.num[63:32] >= req.den)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    run_reg <= 1'b1;
                end
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(DIV_STEPS - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            ovf_reg <= req.num[63:32] >= req.den;
            rem_reg <= {32'd0, req.num[63:32]};
            lo_reg  <= req.num[31:0];
            den_reg <= req.den;
            quo_reg <= '0;
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? 64'(trial - {1'b0, den_reg}) : trial[63:0];
            lo_reg  <= {lo_reg[30:0], 1'b0};
            quo_reg <= {quo_reg[30:0], ge};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.ovf  = ovf_reg;
    assign rsp.quo  = quo_reg;

endmodule

// ----- src/nbgr_fifo.sv -----
// Small command queue between the loading front end and the compute back end.
module nbgr_fifo #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);
    import nbgr_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [NW-1:0]    fill_reg;

    assign full      = fill_reg == NW'(DEPTH);
    assign not_empty = fill_reg != '0;
    assign pop_data  = slot_reg[rd_ptr_reg];

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + NW'(1);
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - NW'(1);
            end
        end
    end

    // Hold entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- src/nbgr_front.sv -----
// Front end: accepts body beats, writes the body store, queues a run on the last beat.
module nbgr_front #(
    parameter int MAX_BODIES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [159:0]                  s_tdata,
    input  logic                          s_tlast,
    output logic                          st_we,
    output logic [$clog2(MAX_BODIES)-1:0] st_addr,
    output nbgr_pkg::body_t               st_data,
    output logic                          q_push,
    output logic [$clog2(MAX_BODIES+1)-1:0] q_data,
    input  logic                          q_full,
    input  logic                          run_done
);
    import nbgr_pkg::*;

    localparam int AW = $clog2(MAX_BODIES);
    localparam int CW = $clog2(MAX_BODIES + 1);

    logic [CW-1:0] count_reg;
    logic          busy_reg;
    logic          beat;
    logic          has_room;

    assign s_tready = !busy_reg && !q_full;
    assign beat     = s_tvalid && s_tready;
    assign has_room = count_reg < CW'(MAX_BODIES);

    // Store write; drop the beat when the store is full
    assign st_we   = beat && has_room;
    assign st_addr = count_reg[AW-1:0];
    assign st_data = s_tdata[BODY_W-1:0];

    // Queue a run when the last body arrives
    assign q_push = beat && s_tlast;
    assign q_data = has_room ? count_reg + CW'(1) : count_reg;

    // Count bodies, hold off loading while a run is in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            if (beat)
            begin
                if (s_tlast)
                begin
                    count_reg <= '0;
                    busy_reg  <= 1'b1;
                end
                else if (has_room)
                begin
                    count_reg <= count_reg + CW'(1);
                end
            end
            else if (run_done)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

endmodule

// ----- src/nbgr_back.sv -----
// Back end: body store, pairwise force sequencer with shared divider, result register.
module nbgr_back #(
    parameter int MAX_BODIES = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            st_we,
    input  logic [$clog2(MAX_BODIES)-1:0]   st_addr,
    input  nbgr_pkg::body_t                 st_data,
    input  logic                            q_valid,
    input  logic [$clog2(MAX_BODIES+1)-1:0] q_data,
    output logic                            q_pop,
    output logic                            run_done,
    input  logic [47:0]                     gr_coef,
    input  logic [30:0]                     thr,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [127:0]                    m_tdata,
    output logic                            m_tlast
);
    import nbgr_pkg::*;

    localparam int AW = $clog2(MAX_BODIES);
    localparam int CW = $clog2(MAX_BODIES + 1);

    bk_state_t state_reg, state_next;

    body_t store [MAX_BODIES];
    body_t rd_data_reg;
    logic [AW-1:0] rd_addr;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [CW-1:0] n_reg, k_reg, j_reg;

    logic signed [31:0] vx_reg, vy_reg, px_reg, py_reg;
    logic signed [63:0] ml_a_reg, ml_b_reg;
    logic [63:0] sq_a_reg, sq_b_reg;
    logic [61:0] thr_sq_reg;
    logic [63:0] ul_reg;
    logic        on_reg;
    logic signed [ACC_W-1:0] acc_x_reg, acc_y_reg;

    logic [30:0] mj_reg;
    logic        dxn_reg, dyn_reg;
    logic [32:0] adx_reg, ady_reg;
    logic [64:0] sqx_reg, sqy_reg;
    logic [63:0] r2_reg;
    logic [63:0] sq_val_reg;
    logic [35:0] sq_rem_reg;
    logic [31:0] r_reg;
    logic [4:0]  step_reg;
    logic [31:0] base_reg, q_reg, f_reg;
    logic        qovf_reg;
    logic [43:0] q2_reg;
    logic [67:0] plo_reg, phi_reg;
    logic [52:0] corr_reg, fac_reg;
    logic [58:0] flo_reg;
    logic [57:0] fhi_reg;
    logic [30:0] ux_reg, uy_reg;
    logic [62:0] prod_reg;

    logic          out_valid_reg;
    logic [127:0]  out_data_reg;
    logic          out_last_reg;

    logic [31:0] axk, ayk;
    logic [64:0] l_c, ul_c;
    logic [32:0] dx_c, dy_c;
    logic [63:0] r2_c;
    logic [35:0] sq_t, sq_trial;
    logic        sq_ge;
    logic [63:0] qq_c;
    logic [91:0] csum_c;
    logic [63:0] gr_sh_c;
    logic [84:0] fsum_c;
    logic [64:0] fres_c;
    logic signed [ACC_W-1:0] term_c;
    logic        k_last;

    // Clamp the accumulator to 32 bits
    function automatic logic [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic [31:0] res;
        if (v[ACC_W-1:31] == '0 || v[ACC_W-1:31] == '1)
        begin
            res = v[31:0];
        end
        else
        begin
            res = v[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return res;
    endfunction

    nbgr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Body store, written by the front end, registered read
    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            store[st_addr] <= st_data;
        end
        rd_data_reg <= store[rd_addr];
    end

    // Combinational arithmetic helpers
    always_comb
    begin
        axk      = px_reg[31] ? 32'(~px_reg + 32'sd1) : px_reg;
        ayk      = py_reg[31] ? 32'(~py_reg + 32'sd1) : py_reg;
        l_c      = {ml_a_reg[63], ml_a_reg} - {ml_b_reg[63], ml_b_reg};
        ul_c     = l_c[64] ? (~l_c + 65'd1) : l_c;
        dx_c     = {rd_data_reg.pos_x[31], rd_data_reg.pos_x} - {px_reg[31], px_reg};
        dy_c     = {rd_data_reg.pos_y[31], rd_data_reg.pos_y} - {py_reg[31], py_reg};
        r2_c     = {1'b0, sqx_reg[64:2]} + {1'b0, sqy_reg[64:2]};
        sq_t     = {sq_rem_reg[33:0], sq_val_reg[63:62]};
        sq_trial = {2'b00, r_reg, 2'b01};
        sq_ge    = sq_t >= sq_trial;
        qq_c     = q_reg * q_reg;
        csum_c   = {phi_reg, 24'd0} + {24'd0, plo_reg};
        gr_sh_c  = {gr_coef, 16'd0} - 64'd1;
        fsum_c   = {fhi_reg, 27'd0} + {26'd0, flo_reg};
        fres_c   = fsum_c[84:20];
        term_c   = $signed({{(ACC_W-33){1'b0}}, prod_reg[62:30]});
        k_last   = (k_reg + CW'(1)) == n_reg;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:   if (q_valid) state_next = BK_KRD;
            BK_KRD:    state_next = BK_KLAT;
            BK_KLAT:   state_next = BK_KM1;
            BK_KM1:    state_next = BK_KM2;
            BK_KM2:    state_next = BK_KM3;
            BK_KM3:    state_next = BK_KM4;
            BK_KM4:    state_next = BK_KM5;
            BK_KM5:    state_next = BK_KSET;
            BK_KSET:   state_next = BK_JRD;
            BK_JRD:
            begin
                if (j_reg == n_reg)
                begin
                    state_next = BK_KOUT;
                end
                else if (j_reg != k_reg)
                begin
                    state_next = BK_JLAT;
                end
            end
            BK_JLAT:   state_next = BK_JSQX;
            BK_JSQX:   state_next = BK_JSQY;
            BK_JSQY:   state_next = BK_JR2;
            BK_JR2:    state_next = (r2_c == '0) ? BK_JRD : BK_JSQRT;
            BK_JSQRT:  if (step_reg == 5'(SQRT_STEPS - 1)) state_next = BK_JBASE;
            BK_JBASE:  state_next = BK_JBASEW;
            BK_JBASEW: if (div_rsp.done) state_next = on_reg ? BK_JQ : BK_JUX;
            BK_JQ:     state_next = BK_JQW;
            BK_JQW:    if (div_rsp.done) state_next = BK_JQ2;
            BK_JQ2:    state_next = BK_JC1;
            BK_JC1:    state_next = BK_JC2;
            BK_JC2:    state_next = BK_JCORR;
            BK_JCORR:  state_next = BK_JFAC;
            BK_JFAC:   state_next = BK_JF1;
            BK_JF1:    state_next = BK_JF2;
            BK_JF2:    state_next = BK_JF;
            BK_JF:     state_next = BK_JUX;
            BK_JUX:    state_next = BK_JUXW;
            BK_JUXW:   if (div_rsp.done) state_next = BK_JUY;
            BK_JUY:    state_next = BK_JUYW;
            BK_JUYW:   if (div_rsp.done) state_next = BK_JTX;
            BK_JTX:    state_next = BK_JTY;
            BK_JTY:    state_next = BK_JACC;
            BK_JACC:   state_next = BK_JRD;
            BK_KOUT:   if (!out_valid_reg) state_next = k_last ? BK_DONE : BK_KRD;
            BK_DONE:   state_next = BK_IDLE;
            default:   state_next = BK_IDLE;
        endcase
    end

    // Outputs: store address, divider requests, queue pop, run done
    always_comb
    begin
        rd_addr     = (state_reg == BK_JRD) ? j_reg[AW-1:0] : k_reg[AW-1:0];
        q_pop       = (state_reg == BK_IDLE) && q_valid;
        run_done    = state_reg == BK_DONE;
        div_req     = '0;
        case (state_reg)
            BK_JBASE:
            begin
                div_req.start = 1'b1;
                div_req.num   = {1'b0, mj_reg, 32'd0};
                div_req.den   = {6'd0, r2_reg[63:6]};
            end
            BK_JQ:
            begin
                div_req.start = 1'b1;
                div_req.num   = ul_reg;
                div_req.den   = {31'd0, r_reg, 1'b0};
            end
            BK_JUX:
            begin
                div_req.start = 1'b1;
                div_req.num   = {2'd0, adx_reg, 29'd0};
                div_req.den   = {32'd0, r_reg};
            end
            BK_JUY:
            begin
                div_req.start = 1'b1;
                div_req.num   = {2'd0, ady_reg, 29'd0};
                div_req.den   = {32'd0, r_reg};
            end
            default:
            begin
                div_req = '0;
            end
        endcase
    end

    // State and result handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == BK_KOUT && !out_valid_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            BK_IDLE:
            begin
                n_reg <= q_data;
                k_reg <= '0;
            end
            BK_KLAT:
            begin
                vx_reg    <= rd_data_reg.vel_x;
                vy_reg    <= rd_data_reg.vel_y;
                px_reg    <= rd_data_reg.pos_x;
                py_reg    <= rd_data_reg.pos_y;
                acc_x_reg <= '0;
                acc_y_reg <= '0;
                j_reg     <= '0;
            end
            BK_KM1: ml_a_reg   <= px_reg * vy_reg;
            BK_KM2: ml_b_reg   <= py_reg * vx_reg;
            BK_KM3: sq_a_reg   <= axk * axk;
            BK_KM4: sq_b_reg   <= ayk * ayk;
            BK_KM5: thr_sq_reg <= thr * thr;
            BK_KSET:
            begin
                ul_reg <= ul_c[63:0];
                on_reg <= ({1'b0, sq_a_reg} + {1'b0, sq_b_reg}) > {3'd0, thr_sq_reg};
            end
            BK_JRD:
            begin
                if (j_reg != n_reg && j_reg == k_reg)
                begin
                    j_reg <= j_reg + CW'(1);
                end
            end
            BK_JLAT:
            begin
                mj_reg  <= rd_data_reg.mass;
                dxn_reg <= dx_c[32];
                dyn_reg <= dy_c[32];
                adx_reg <= dx_c[32] ? (~dx_c + 33'd1) : dx_c;
                ady_reg <= dy_c[32] ? (~dy_c + 33'd1) : dy_c;
            end
            BK_JSQX: sqx_reg <= adx_reg * adx_reg;
            BK_JSQY: sqy_reg <= ady_reg * ady_reg;
            BK_JR2:
            begin
                r2_reg     <= r2_c;
                sq_val_reg <= r2_c;
                sq_rem_reg <= '0;
                r_reg      <= '0;
                step_reg   <= '0;
                if (r2_c == '0)
                begin
                    j_reg <= j_reg + CW'(1);
                end
            end
            BK_JSQRT:
            begin
                sq_rem_reg <= sq_ge ? (sq_t - sq_trial) : sq_t;
                r_reg      <= {r_reg[30:0], sq_ge};
                sq_val_reg <= {sq_val_reg[61:0], 2'b00};
                step_reg   <= step_reg + 5'd1;
            end
            BK_JBASEW:
            begin
                if (div_rsp.done)
                begin
                    base_reg <= div_rsp.ovf ? F_CAP : div_rsp.quo;
                    f_reg    <= div_rsp.ovf ? F_CAP : div_rsp.quo;
                end
            end
            BK_JQW:
            begin
                if (div_rsp.done)
                begin
                    q_reg    <= div_rsp.quo;
                    qovf_reg <= div_rsp.ovf;
                end
            end
            BK_JQ2: q2_reg  <= qq_c[63:20];
            BK_JC1: plo_reg <= gr_coef[23:0] * q2_reg;
            BK_JC2: phi_reg <= gr_coef[47:24] * q2_reg;
            BK_JCORR:
            begin
                if (!qovf_reg)
                begin
                    corr_reg <= {9'd0, csum_c[91:48]};
                end
                else if (gr_coef == '0)
                begin
                    corr_reg <= '0;
                end
                else if (gr_coef > GR_SAT_LIM)
                begin
                    corr_reg <= CORR_CAP;
                end
                else
                begin
                    corr_reg <= gr_sh_c[52:0];
                end
            end
            BK_JFAC: fac_reg <= corr_reg + ONE_Q20;
            BK_JF1:  flo_reg <= base_reg * fac_reg[26:0];
            BK_JF2:  fhi_reg <= base_reg * fac_reg[52:27];
            BK_JF:   f_reg   <= (fres_c[64:32] != '0) ? F_CAP : fres_c[31:0];
            BK_JUXW:
            begin
                if (div_rsp.done)
                begin
                    ux_reg <= (div_rsp.ovf || div_rsp.quo > {1'b0, UNIT_CAP})
                              ? UNIT_CAP : div_rsp.quo[30:0];
                end
            end
            BK_JUYW:
            begin
                if (div_rsp.done)
                begin
                    uy_reg <= (div_rsp.ovf || div_rsp.quo > {1'b0, UNIT_CAP})
                              ? UNIT_CAP : div_rsp.quo[30:0];
                end
            end
            BK_JTX: prod_reg <= f_reg * ux_reg;
            BK_JTY:
            begin
                acc_x_reg <= dxn_reg ? acc_x_reg - term_c : acc_x_reg + term_c;
                prod_reg  <= f_reg * uy_reg;
            end
            BK_JACC:
            begin
                acc_y_reg <= dyn_reg ? acc_y_reg - term_c : acc_y_reg + term_c;
                j_reg     <= j_reg + CW'(1);
            end
            BK_KOUT:
            begin
                if (!out_valid_reg)
                begin
                    out_data_reg <= {vy_reg, vx_reg, sat32(acc_y_reg), sat32(acc_x_reg)};
                    out_last_reg <= k_last;
                    k_reg        <= k_reg + CW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ----- src/nbody_gr_acceleration_unit.sv -----
// Top level: config registers, front end, run queue and compute back end.
// Loading: one body beat per cycle while s_tready is high; the beat marked last starts a run of N bodies.
// Per body: setup and output states plus, for each other body, a square root and three
// 32-step divisions, or four divisions with the correction on.
// A run of N bodies computes N*(N-1) pairs; the shared divider sets the pace.
// Reset clears control state and loads config defaults; the body store is not cleared.
module nbody_gr_acceleration_unit #(
    parameter int MAX_BODIES = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [159:0] s_tdata,   // vel_x, vel_y, pos_x, pos_y, mass, pad
    input  logic         s_tlast,   // last_body
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // acc_x, acc_y, rate_x, rate_y
    output logic         m_tlast,   // last_result
    input  logic         cfg_we,
    input  logic [0:0]   cfg_index,
    input  logic [47:0]  cfg_data
);
    import nbgr_pkg::*;

    localparam int AW = $clog2(MAX_BODIES);
    localparam int CW = $clog2(MAX_BODIES + 1);

    logic [47:0]   gr_coef_reg;
    logic [30:0]   thr_reg;
    logic          st_we;
    logic [AW-1:0] st_addr;
    body_t         st_data;
    logic          q_push, q_full, q_valid, q_pop, run_done;
    logic [CW-1:0] q_in, q_out;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gr_coef_reg <= GR_COEF_RESET;
            thr_reg     <= THR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GR_COEF: gr_coef_reg <= cfg_data;
                CFG_THR:     thr_reg     <= cfg_data[30:0];
                default:     gr_coef_reg <= gr_coef_reg;
            endcase
        end
    end

    nbgr_front #(.MAX_BODIES(MAX_BODIES)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .st_we    (st_we),
        .st_addr  (st_addr),
        .st_data  (st_data),
        .q_push   (q_push),
        .q_data   (q_in),
        .q_full   (q_full),
        .run_done (run_done)
    );

    nbgr_fifo #(.WIDTH(CW), .DEPTH(2)) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_out)
    );

    nbgr_back #(.MAX_BODIES(MAX_BODIES)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .st_we    (st_we),
        .st_addr  (st_addr),
        .st_data  (st_data),
        .q_valid  (q_valid),
        .q_data   (q_out),
        .q_pop    (q_pop),
        .run_done (run_done),
        .gr_coef  (gr_coef_reg),
        .thr      (thr_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Loading stops once a run has been queued
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("beat accepted after last body");

    // Never push into a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("run queue overflow");

    // A run finishes with nothing else queued
    assert property (@(posedge clk) disable iff (!rst_n)
        run_done |-> !q_valid)
        else $error("run queue not empty at end of run");

endmodule
